>>> hw/rtl/plin_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// plin_pkg
// Shared types, register codes and reset values of the piecewise linear
// interpolator.
// ============================================================================
package plin_pkg;

    localparam int DataW     = 32;
    localparam int CfgIdxW   = 3;
    localparam int CellCount = 32;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_POINT_COUNT = 3'd0,
        CFG_DOMAIN_0    = 3'd1,
        CFG_DOMAIN_1    = 3'd2,
        CFG_DOMAIN_2    = 3'd3,
        CFG_RANGE_0     = 3'd4,
        CFG_RANGE_1     = 3'd5,
        CFG_RANGE_2     = 3'd6
    } plin_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_LOW    = 2'd1,
        ST_HIGH   = 2'd2,
        ST_NONE   = 2'd3
    } plin_status_t;

    localparam logic [1:0]       RST_POINT_COUNT = 2'd3;
    localparam logic [DataW-1:0] RST_DOMAIN_0    = 32'd0;
    localparam logic [DataW-1:0] RST_DOMAIN_1    = 32'd655360000;
    localparam logic [DataW-1:0] RST_DOMAIN_2    = 32'd1310720000;
    localparam logic [DataW-1:0] RST_RANGE_0     = 32'd642712;
    localparam logic [DataW-1:0] RST_RANGE_1     = 32'd639894;
    localparam logic [DataW-1:0] RST_RANGE_2     = 32'd637075;

    typedef struct packed {
        logic [1:0]            point_count;
        logic [2:0][DataW-1:0] dom;
        logic [2:0][DataW-1:0] rng;
    } plin_cfg_t;

    // What travels beside the arithmetic to the final stage.
    typedef struct packed {
        plin_status_t     status;
        logic             bypass;
        logic             neg;
        logic [DataW-1:0] base;
    } plin_side_t;

    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DataW-1:0] lowq;
        logic [DataW-1:0] den;
        plin_side_t       side;
    } plin_div_t;

endpackage

>>> hw/rtl/plin_setup.sv
`timescale 1ns / 1ps
// ============================================================================
// plin_setup
// Two pipeline stages: segment search and clamp decision, then the segment
// differences that feed the multiplier and the divider.
// ============================================================================
module plin_setup (
    input  logic                     clk,
    input  logic                     rst_n,
    input  plin_pkg::plin_cfg_t      cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [plin_pkg::DataW-1:0] in_x,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [plin_pkg::DataW-1:0] out_mt,
    output logic [plin_pkg::DataW-1:0] out_mdr,
    output logic [plin_pkg::DataW-1:0] out_den,
    output plin_pkg::plin_side_t     out_side
);
    import plin_pkg::*;

    logic                    s1_valid_reg;
    logic [DataW-1:0]        s1_x_reg;
    logic                    s1_seg_reg;
    plin_status_t            s1_status_reg;
    logic [DataW-1:0]        s1_clamp_reg;
    logic                    s1_ready;

    logic                    s2_valid_reg;
    logic [DataW-1:0]        s2_mt_reg;
    logic [DataW-1:0]        s2_mdr_reg;
    logic [DataW-1:0]        s2_den_reg;
    plin_side_t              s2_side_reg;
    logic                    s2_ready;

    logic signed [DataW-1:0] x, d0, d1, d2, dlast;
    logic                    two_up, three, in0, in1;
    logic                    seg_next;
    plin_status_t            status_next;
    logic [DataW-1:0]        clamp_next;
    logic [DataW-1:0]        rlast;

    logic [DataW-1:0]        da, db, ra, rb;
    logic [DataW:0]          den33, t33, dr33, mdr33;
    plin_side_t              side_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: find the first segment holding the query, else the clamp side, else none.
    always_comb
    begin
        x      = $signed(in_x);
        d0     = $signed(cfg.dom[0]);
        d1     = $signed(cfg.dom[1]);
        d2     = $signed(cfg.dom[2]);
        two_up = cfg.point_count[1];
        three  = (cfg.point_count == 2'd3);
        dlast  = three ? d2 : d1;
        rlast  = three ? cfg.rng[2] : cfg.rng[1];
        in0    = two_up && (x >= d0) && (x <= d1);
        in1    = three && (x >= d1) && (x <= d2);
        seg_next    = 1'b0;
        status_next = ST_NONE;
        clamp_next  = '0;
        priority if (!two_up)
        begin
            status_next = ST_NONE;
        end
        else if (in0)
        begin
            status_next = ST_INTERP;
        end
        else if (in1)
        begin
            status_next = ST_INTERP;
            seg_next    = 1'b1;
        end
        else if (x < d0)
        begin
            status_next = ST_LOW;
            clamp_next  = cfg.rng[0];
        end
        else if (x > dlast)
        begin
            status_next = ST_HIGH;
            clamp_next  = rlast;
        end
        else
        begin
            status_next = ST_NONE;
        end
    end

    // Stage 2: differences of the chosen segment.
    always_comb
    begin
        da    = s1_seg_reg ? cfg.dom[1] : cfg.dom[0];
        db    = s1_seg_reg ? cfg.dom[2] : cfg.dom[1];
        ra    = s1_seg_reg ? cfg.rng[1] : cfg.rng[0];
        rb    = s1_seg_reg ? cfg.rng[2] : cfg.rng[1];
        den33 = {db[DataW-1], db} - {da[DataW-1], da};
        t33   = {s1_x_reg[DataW-1], s1_x_reg} - {da[DataW-1], da};
        dr33  = {rb[DataW-1], rb} - {ra[DataW-1], ra};
        mdr33 = dr33[DataW] ? (~dr33 + 1'b1) : dr33;
        side_next.status = s1_status_reg;
        side_next.neg    = dr33[DataW];
        side_next.bypass = (s1_status_reg != ST_INTERP) || (den33[DataW-1:0] == '0);
        side_next.base   = (s1_status_reg == ST_INTERP) ? ra : s1_clamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_x_reg      <= in_x;
            s1_seg_reg    <= seg_next;
            s1_status_reg <= status_next;
            s1_clamp_reg  <= clamp_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_mt_reg   <= t33[DataW-1:0];
            s2_mdr_reg  <= mdr33[DataW-1:0];
            s2_den_reg  <= den33[DataW-1:0];
            s2_side_reg <= side_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_mt    = s2_mt_reg;
    assign out_mdr   = s2_mdr_reg;
    assign out_den   = s2_den_reg;
    assign out_side  = s2_side_reg;

endmodule

>>> hw/rtl/plin_scale.sv
`timescale 1ns / 1ps
// ============================================================================
// plin_scale
// Product of offset and rise, then the half-divisor bias for rounding to
// nearest; loads the first divider cell.
// ============================================================================
module plin_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [plin_pkg::DataW-1:0] in_mt,
    input  logic [plin_pkg::DataW-1:0] in_mdr,
    input  logic [plin_pkg::DataW-1:0] in_den,
    input  plin_pkg::plin_side_t       in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output plin_pkg::plin_div_t        out_data
);
    import plin_pkg::*;

    logic                 m_valid_reg;
    logic [2*DataW-1:0]   m_mag_reg;
    logic [DataW-1:0]     m_den_reg;
    plin_side_t           m_side_reg;
    logic                 m_ready;

    logic                 b_valid_reg;
    plin_div_t            b_data_reg;
    logic                 b_ready;

    logic [2*DataW-1:0]   prod;
    logic [2*DataW-1:0]   biased;

    assign b_ready  = !b_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || b_ready;
    assign in_ready = m_ready;

    assign prod   = in_mt * in_mdr;
    assign biased = m_mag_reg + {{(DataW+1){1'b0}}, m_den_reg[DataW-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && m_ready)
        begin
            m_mag_reg  <= prod;
            m_den_reg  <= in_den;
            m_side_reg <= in_side;
        end
        if (m_valid_reg && b_ready)
        begin
            // The upper half is below the divisor, so the quotient fits in one word.
            b_data_reg.rem  <= biased[2*DataW-1:DataW];
            b_data_reg.lowq <= biased[DataW-1:0];
            b_data_reg.den  <= m_den_reg;
            b_data_reg.side <= m_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

>>> hw/rtl/plin_div_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// plin_div_cell
// One restoring division step: settles one quotient bit and hands the
// partial remainder to the next cell.
// ============================================================================
module plin_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plin_pkg::plin_div_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output plin_pkg::plin_div_t out_data
);
    import plin_pkg::*;

    logic           valid_reg;
    plin_div_t      data_reg;
    plin_div_t      data_next;
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    logic           take;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial = {in_data.rem, in_data.lowq[DataW-1]};
        diff  = trial - {1'b0, in_data.den};
        take  = !diff[DataW];
        data_next      = in_data;
        data_next.rem  = take ? diff[DataW-1:0] : trial[DataW-1:0];
        // Quotient bits shift in behind the dividend bits still to be used.
        data_next.lowq = {in_data.lowq[DataW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/piecewise_linear_interpolator_core.sv
`timescale 1ns / 1ps
// An accepted request passes the setup and scale stages, the divider cells and the
// output register. While the output is not stalled, one request enters per cycle and
// every stage moves in each cycle; the 32-cell divider chain, one quotient bit per
// cell, sets the depth. Stalls on the output fill empty stages first, so requests
// keep entering. Reset empties the pipeline and loads the default breakpoint table.
// ============================================================================
// piecewise_linear_interpolator_core
// Piecewise linear interpolation over two or three breakpoints with end
// clamping, Q16.16 in and out.
// ============================================================================
module piecewise_linear_interpolator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [plin_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [plin_pkg::DataW-1:0]   cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // [31:0] query_value
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,  // [31:0] result_value
    output logic [1:0]                   m_axis_tuser   // [1:0] status
);
    import plin_pkg::*;

    logic [1:0]            point_count_reg;
    logic [2:0][DataW-1:0] dom_reg;
    logic [2:0][DataW-1:0] rng_reg;
    plin_cfg_t             cfg;

    logic                  su_valid, su_ready;
    logic [DataW-1:0]      su_mt, su_mdr, su_den;
    plin_side_t            su_side;

    logic                  div_valid [0:CellCount];
    logic                  div_ready [0:CellCount];
    plin_div_t             div_data  [0:CellCount];

    logic                  out_valid_reg;
    logic [DataW-1:0]      out_value_reg;
    plin_status_t          out_status_reg;
    logic                  fin_ready;
    logic [DataW:0]        sum33;
    logic [DataW-1:0]      value_next;
    plin_div_t             last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= RST_POINT_COUNT;
            dom_reg[0]      <= RST_DOMAIN_0;
            dom_reg[1]      <= RST_DOMAIN_1;
            dom_reg[2]      <= RST_DOMAIN_2;
            rng_reg[0]      <= RST_RANGE_0;
            rng_reg[1]      <= RST_RANGE_1;
            rng_reg[2]      <= RST_RANGE_2;
        end
        else if (cfg_wr_en)
        begin
            unique case (plin_cfg_idx_t'(cfg_index))
                CFG_POINT_COUNT: point_count_reg <= cfg_wdata[1:0];
                CFG_DOMAIN_0:    dom_reg[0]      <= cfg_wdata;
                CFG_DOMAIN_1:    dom_reg[1]      <= cfg_wdata;
                CFG_DOMAIN_2:    dom_reg[2]      <= cfg_wdata;
                CFG_RANGE_0:     rng_reg[0]      <= cfg_wdata;
                CFG_RANGE_1:     rng_reg[1]      <= cfg_wdata;
                CFG_RANGE_2:     rng_reg[2]      <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign cfg.point_count = point_count_reg;
    assign cfg.dom         = dom_reg;
    assign cfg.rng         = rng_reg;

    plin_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (s_axis_tdata),
        .out_valid (su_valid),
        .out_ready (su_ready),
        .out_mt    (su_mt),
        .out_mdr   (su_mdr),
        .out_den   (su_den),
        .out_side  (su_side)
    );

    plin_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .in_ready  (su_ready),
        .in_mt     (su_mt),
        .in_mdr    (su_mdr),
        .in_den    (su_den),
        .in_side   (su_side),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar k = 0; k < CellCount; k++)
    begin : g_div
        plin_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    assign fin_ready            = !out_valid_reg || m_axis_tready;
    assign div_ready[CellCount] = fin_ready;
    assign last                 = div_data[CellCount];

    // The quotient never exceeds the rise of the segment, so the sum stays in range.
    always_comb
    begin
        if (last.side.neg)
        begin
            sum33 = {last.side.base[DataW-1], last.side.base} - {1'b0, last.lowq};
        end
        else
        begin
            sum33 = {last.side.base[DataW-1], last.side.base} + {1'b0, last.lowq};
        end
        value_next = last.side.bypass ? last.side.base : sum33[DataW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            out_valid_reg <= div_valid[CellCount];
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_valid[CellCount] && fin_ready)
        begin
            out_value_reg  <= value_next;
            out_status_reg <= last.side.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

>>> hw/rtl/plin_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// plin_checker
// Port-level checks of the interpolator, bound to the top level.
// ============================================================================
module plin_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [31:0]                  m_axis_tdata,
    input logic [1:0]                   m_axis_tuser
);
    import plin_pkg::*;

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Requests are refused only when every stage is full behind a stalled output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request refused with room in the pipeline");

    // A query with no segment gives zero.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NONE) |-> m_axis_tdata == '0)
        else $error("no-segment result is not zero");

    // Once reset has been seen at an edge, the pipeline is empty in the next cycle.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

bind piecewise_linear_interpolator_core plin_checker u_checker (.*);
